/* design/tcss_pkg.sv */
// Shared constants, codes and types of the triple copy settings store.
`default_nettype none

package tcss_pkg;

  localparam int SETTING_BYTES = 16;
  localparam int BASE_ADDRESS  = 8;
  localparam int MAGIC_ADDRESS = 4;

  localparam int SHADOW_ADDR_W = (SETTING_BYTES > 1) ? $clog2(SETTING_BYTES) : 1;

  localparam logic [13:0] LIMIT_RESET = 14'd10000;
  localparam logic [13:0] COUNT_MAX   = 14'h3FFF;

  typedef enum logic [1:0] {
    CMD_POLL    = 2'd0,
    CMD_RESTORE = 2'd1,
    CMD_SEED    = 2'd2,
    CMD_UNUSED  = 2'd3
  } tcss_cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_RESTORED = 2'd2,
    KIND_FAULT    = 2'd3
  } tcss_kind_t;

  typedef struct packed {
    tcss_cmd_t   command;
    logic [3:0]  byte_index;
    logic [7:0]  data_value;
    logic [7:0]  second_copy;
    logic [7:0]  third_copy;
    logic        scan_end;
  } tcss_item_t;

  typedef struct packed {
    tcss_kind_t  kind;
    logic [7:0]  nv_address;
    logic [7:0]  out_data;
    logic        write_disabled;
    logic        last;
  } tcss_result_t;

endpackage

`default_nettype wire

/* design/triple_copy_settings_store.sv */
// Top level of the triple copy settings store: stream ports, limit register, shadow RAM.
`default_nettype none

// Each accepted item is captured in the sequencer together with the shadow RAM
// read, then voted or compared with the write-back, then sends its results
// through the one-entry output register, waiting while that register is full:
// one result for an acknowledge, restore or fault, three for a changed poll
// byte that sends its three copy writes. A finished result may wait in the
// output register while the next item is taken.
// After a fault the block keeps accepting items but returns nothing until reset;
// the write limit register accepts writes at any time.
module triple_copy_settings_store
  import tcss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // byte_index[3:0], data_value[11:4], second_copy[19:12], third_copy[27:20], zero[31:28]
  input  wire logic [31:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // nv_address[7:0], out_data[15:8], write_disabled[16], zero[23:17]
  output logic [23:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [13:0] cfg_data
);

  logic [13:0]              write_limit;
  tcss_item_t               in_item;
  tcss_result_t             result;
  logic                     mem_wr_en;
  logic [SHADOW_ADDR_W-1:0] mem_wr_addr;
  logic [7:0]               mem_wr_data;
  logic [SHADOW_ADDR_W-1:0] mem_rd_addr;
  logic [7:0]               mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      write_limit <= cfg_data;
    end
  end

  assign in_item.command     = tcss_cmd_t'(s_axis_tuser);
  assign in_item.byte_index  = s_axis_tdata[3:0];
  assign in_item.data_value  = s_axis_tdata[11:4];
  assign in_item.second_copy = s_axis_tdata[19:12];
  assign in_item.third_copy  = s_axis_tdata[27:20];
  assign in_item.scan_end    = s_axis_tlast;

  tcss_ram #(
    .WIDTH (8),
    .DEPTH (SETTING_BYTES)
  ) u_shadow (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  tcss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .write_limit (write_limit),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (result)
  );

  assign m_axis_tdata = {7'd0, result.write_disabled, result.out_data, result.nv_address};
  assign m_axis_tuser = result.kind;
  assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

/* design/tcss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/tcss_ctrl.sv */
// Read-modify-write sequencer over the shadow RAM, wear counter and result register.
`default_nettype none

module tcss_ctrl
  import tcss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire tcss_item_t               in_item,
  input  wire logic [13:0]              write_limit,
  output logic                          mem_wr_en,
  output logic [SHADOW_ADDR_W-1:0]      mem_wr_addr,
  output logic [7:0]                    mem_wr_data,
  output logic [SHADOW_ADDR_W-1:0]      mem_rd_addr,
  input  wire logic [7:0]               mem_rd_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output tcss_result_t                  out_result
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SEND} state_t;

  localparam logic [7:0] BASE_A  = 8'(BASE_ADDRESS);
  localparam logic [7:0] MAGIC_A = 8'(MAGIC_ADDRESS);
  localparam logic [7:0] STEP_A  = 8'(SETTING_BYTES);

  state_t      state;
  tcss_item_t  item;
  logic [13:0] write_count;
  logic        writes_off;
  logic        halted;

  tcss_kind_t  res_kind;
  logic [7:0]  res_addr;
  logic [7:0]  res_data;
  logic [1:0]  beats;

  logic [13:0] count_next;
  logic        writes_off_next;
  logic        halted_next;
  logic        wr_req;
  tcss_kind_t  kind_next;
  logic [7:0]  addr_next;
  logic [7:0]  data_next;
  logic [1:0]  beats_next;
  logic        in_range;
  logic        poll_act;
  logic [7:0]  voted;
  logic        vote_ok;
  logic        push;

  logic [SHADOW_ADDR_W+3:0] in_idx_wide;
  logic [SHADOW_ADDR_W+3:0] cap_idx_wide;

  assign in_idx_wide  = {{SHADOW_ADDR_W{1'b0}}, in_item.byte_index};
  assign cap_idx_wide = {{SHADOW_ADDR_W{1'b0}}, item.byte_index};
  assign mem_rd_addr  = in_idx_wide[SHADOW_ADDR_W-1:0];
  assign mem_wr_addr  = cap_idx_wide[SHADOW_ADDR_W-1:0];

  assign in_ready  = (state == ST_IDLE);
  assign push      = (state == ST_SEND) && (!out_valid || out_ready);
  assign mem_wr_en = (state == ST_READ) && wr_req;

  assign in_range = (int'(item.byte_index) < SETTING_BYTES);
  assign poll_act = !writes_off && in_range;

  always_comb begin
    if ((item.data_value == item.second_copy) || (item.data_value == item.third_copy)) begin
      voted   = item.data_value;
      vote_ok = 1'b1;
    end else if (item.second_copy == item.third_copy) begin
      voted   = item.third_copy;
      vote_ok = 1'b1;
    end else begin
      voted   = item.third_copy;
      vote_ok = 1'b0;
    end
  end

  always_comb begin
    count_next      = write_count;
    writes_off_next = writes_off;
    halted_next     = halted;
    wr_req          = 1'b0;
    mem_wr_data     = item.data_value;
    kind_next       = KIND_ACK;
    addr_next       = 8'd0;
    data_next       = 8'd0;
    beats_next      = 2'd1;
    case (item.command)
      CMD_POLL: begin
        if (poll_act && (mem_rd_data != item.data_value)) begin
          wr_req     = 1'b1;
          count_next = (write_count == COUNT_MAX) ? write_count : write_count + 14'd1;
          kind_next  = KIND_WRITE;
          addr_next  = BASE_A + {4'd0, item.byte_index};
          data_next  = item.data_value;
          beats_next = 2'd3;
        end
        if (poll_act && item.scan_end && (count_next > write_limit)) begin
          writes_off_next = 1'b1;
        end
      end
      CMD_RESTORE: begin
        if (in_range && vote_ok) begin
          wr_req      = 1'b1;
          mem_wr_data = voted;
          kind_next   = KIND_RESTORED;
          data_next   = voted;
        end else if (in_range) begin
          halted_next = 1'b1;
          kind_next   = KIND_FAULT;
          addr_next   = MAGIC_A;
        end
      end
      CMD_SEED: begin
        if (in_range) begin
          wr_req      = 1'b1;
          mem_wr_data = item.data_value + 8'd1;
        end
      end
      default: begin
        kind_next = KIND_ACK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_count <= 14'd0;
      writes_off  <= 1'b0;
      halted      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            if (!halted) begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          write_count <= count_next;
          writes_off  <= writes_off_next;
          halted      <= halted_next;
          res_kind    <= kind_next;
          res_addr    <= addr_next;
          res_data    <= data_next;
          beats       <= beats_next;
          state       <= ST_SEND;
        end
        ST_SEND: begin
          if (push) begin
            out_valid                 <= 1'b1;
            out_result.kind           <= res_kind;
            out_result.nv_address     <= res_addr;
            out_result.out_data       <= res_data;
            out_result.write_disabled <= writes_off;
            out_result.last           <= (beats == 2'd1);
            res_addr                  <= res_addr + STEP_A;
            beats                     <= beats - 2'd1;
            if (beats == 2'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/tb_triple_copy_settings_store.sv */
// Self-checking testbench of the triple copy settings store: stream traffic, wear limit, fault halt.
module tb_triple_copy_settings_store;
  import tcss_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SHOWN_ERRORS   = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data = '0;

  triple_copy_settings_store u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  logic [7:0]  shadow_mirror [SETTING_BYTES];
  bit          shadow_known  [SETTING_BYTES];
  logic [13:0] wear_count   = '0;
  logic [13:0] wear_limit   = LIMIT_RESET;
  logic        wear_lock    = 1'b0;
  logic        store_halted = 1'b0;

  tcss_result_t expected_results [$];
  int mismatch_count = 0;
  int burst_left     = 0;
  int hold_request   = 0;
  int idle_cycles    = 0;

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS) $display("%s", msg);
  endfunction

  function automatic void predict_settings_results(input tcss_item_t it);
    tcss_result_t r;
    logic [7:0]   voted;
    logic         changed;
    int unsigned  i;
    if (store_halted) return;
    i = it.byte_index;
    changed = 1'b0;
    r.kind = KIND_ACK;
    r.nv_address = 8'h00;
    r.out_data = 8'h00;
    r.last = 1'b1;
    case (it.command)
      CMD_POLL: begin
        if (!wear_lock && i < SETTING_BYTES) begin
          if (shadow_mirror[i] != it.data_value) begin
            shadow_mirror[i] = it.data_value;
            if (wear_count != COUNT_MAX) wear_count++;
            changed = 1'b1;
          end
          if (it.scan_end && wear_count > wear_limit) wear_lock = 1'b1;
        end
      end
      CMD_RESTORE: begin
        if (i < SETTING_BYTES) begin
          if (it.data_value == it.second_copy || it.data_value == it.third_copy) begin
            voted = it.data_value;
          end else begin
            voted = it.third_copy;
          end
          if (it.data_value != it.second_copy && it.data_value != it.third_copy &&
              it.second_copy != it.third_copy) begin
            store_halted = 1'b1;
            r.kind = KIND_FAULT;
            r.nv_address = 8'(MAGIC_ADDRESS);
          end else begin
            shadow_mirror[i] = voted;
            shadow_known[i] = 1'b1;
            r.kind = KIND_RESTORED;
            r.out_data = voted;
          end
        end
      end
      CMD_SEED: begin
        if (i < SETTING_BYTES) begin
          shadow_mirror[i] = it.data_value + 8'd1;
          shadow_known[i] = 1'b1;
        end
      end
      default: ;
    endcase
    r.write_disabled = wear_lock;
    if (changed) begin
      for (int k = 0; k < 3; k++) begin
        r.kind = KIND_WRITE;
        r.nv_address = 8'(BASE_ADDRESS + i + k * SETTING_BYTES);
        r.out_data = it.data_value;
        r.last = (k == 2);
        expected_results.push_back(r);
      end
    end else begin
      expected_results.push_back(r);
    end
  endfunction

  function automatic tcss_item_t build_item(input tcss_cmd_t cmd, input int idx, input int a,
                                            input int b, input int c, input bit se);
    tcss_item_t it;
    it.command = cmd;
    it.byte_index = 4'(idx);
    it.data_value = 8'(a);
    it.second_copy = 8'(b);
    it.third_copy = 8'(c);
    it.scan_end = se;
    return it;
  endfunction

  // never poll a shadow byte that has not been written: seed it instead
  function automatic tcss_item_t poll_item(input int idx, input bit change, input bit se);
    logic [7:0] v;
    if (!shadow_known[idx]) begin
      return build_item(CMD_SEED, idx, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), se);
    end
    v = change ? (shadow_mirror[idx] ^ 8'($urandom_range(1, 255))) : shadow_mirror[idx];
    return build_item(CMD_POLL, idx, v, $urandom_range(0, 255), $urandom_range(0, 255), se);
  endfunction

  function automatic tcss_item_t restore_item(input int idx);
    logic [7:0] v;
    logic [7:0] odd;
    v = 8'($urandom_range(0, 255));
    odd = v ^ 8'($urandom_range(1, 255));
    case ($urandom_range(0, 3))
      0: return build_item(CMD_RESTORE, idx, v, v, v, $urandom_range(0, 1));
      1: return build_item(CMD_RESTORE, idx, v, v, odd, $urandom_range(0, 1));
      2: return build_item(CMD_RESTORE, idx, v, odd, v, $urandom_range(0, 1));
      default: return build_item(CMD_RESTORE, idx, odd, v, v, $urandom_range(0, 1));
    endcase
  endfunction

  function automatic tcss_item_t noise_item();
    tcss_cmd_t cmd;
    int        idx;
    cmd = tcss_cmd_t'($urandom_range(0, 3));
    idx = $urandom_range(0, SETTING_BYTES - 1);
    case (cmd)
      CMD_POLL:    return poll_item(idx, $urandom_range(0, 1), $urandom_range(0, 1));
      CMD_RESTORE: return restore_item(idx);
      default:     return build_item(cmd, idx, $urandom_range(0, 255), $urandom_range(0, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_settings_item(input tcss_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, it.third_copy, it.second_copy, it.data_value, it.byte_index};
    s_axis_tuser  <= it.command;
    s_axis_tlast  <= it.scan_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    predict_settings_results(it);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_wear_limit(input logic [13:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    wear_limit = value;
    @(posedge clk);
  endtask

  // scans of consecutive polls closed by scan_end, with other commands mixed in
  task automatic run_random_scans(input int n_items);
    int sent;
    int scan_len;
    int start;
    sent = 0;
    while (sent < n_items) begin
      scan_len = $urandom_range(1, SETTING_BYTES);
      start = $urandom_range(0, SETTING_BYTES - 1);
      for (int k = 0; k < scan_len; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          send_settings_item(noise_item());
        end else begin
          send_settings_item(poll_item((start + k) % SETTING_BYTES, $urandom_range(0, 1),
                                       k == scan_len - 1));
        end
        sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_settings_item(build_item(CMD_SEED,    0,  8'hFF, 8'h00, 8'h00, 1'b0));
    send_settings_item(build_item(CMD_SEED,    15, 8'h00, 8'hFF, 8'hFF, 1'b0));
    send_settings_item(build_item(CMD_POLL,    0,  8'h00, 8'h00, 8'h00, 1'b0));
    send_settings_item(build_item(CMD_POLL,    0,  8'hFF, 8'h00, 8'h00, 1'b1));
    send_settings_item(build_item(CMD_POLL,    15, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_settings_item(build_item(CMD_RESTORE, 3,  8'hAA, 8'hAA, 8'hAA, 1'b0));
    send_settings_item(build_item(CMD_RESTORE, 4,  8'h12, 8'h12, 8'h34, 1'b0));
    send_settings_item(build_item(CMD_RESTORE, 5,  8'h56, 8'h78, 8'h56, 1'b0));
    send_settings_item(build_item(CMD_RESTORE, 6,  8'h9A, 8'hBC, 8'hBC, 1'b0));
    send_settings_item(build_item(CMD_UNUSED,  7,  8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_settings_item(build_item(CMD_SEED,    7,  8'h80, 8'h00, 8'h00, 1'b1));
    send_settings_item(build_item(CMD_RESTORE, 8,  8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_settings_item(build_item(CMD_POLL,    3,  8'h00, 8'h00, 8'h00, 1'b1));
    send_settings_item(build_item(CMD_POLL,    7,  8'h81, 8'h00, 8'h00, 1'b0));
    send_settings_item(build_item(CMD_POLL,    15, 8'h00, 8'h00, 8'h00, 1'b1));
    drain_results();
  endtask

  task automatic test_random_traffic();
    write_wear_limit(COUNT_MAX);
    run_random_scans(90);
    drain_results();
    write_wear_limit(14'($urandom_range(2000, 16000)));
    run_random_scans(90);
    drain_results();
    write_wear_limit(COUNT_MAX - 14'd1);
    run_random_scans(90);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    burst_left = 64;
    for (int n = 0; n < 24; n++) begin
      send_settings_item(poll_item($urandom_range(0, SETTING_BYTES - 1), 1'b1, 1'b0));
    end
    drain_results();
  endtask

  // count equal to the limit must not lock writes; only a count above it does
  task automatic test_limit_boundary();
    write_wear_limit(wear_count);
    send_settings_item(build_item(CMD_SEED, 9, 8'h3C, 8'h00, 8'h00, 1'b0));
    send_settings_item(build_item(CMD_POLL, 9, 8'h3D, 8'h00, 8'h00, 1'b1));
    send_settings_item(build_item(CMD_POLL, 9, 8'hC3, 8'h00, 8'h00, 1'b0));
    drain_results();
  endtask

  task automatic test_changed_polls();
    write_wear_limit(COUNT_MAX);
    for (int n = 0; n < 24; n++) begin
      send_settings_item(poll_item($urandom_range(0, SETTING_BYTES - 1), 1'b1,
                                   $urandom_range(0, 3) == 0));
    end
    send_settings_item(poll_item(2, 1'b1, 1'b1));
    drain_results();
  endtask

  task automatic test_wear_lockout();
    write_wear_limit(14'd0);
    send_settings_item(poll_item(2, 1'b1, 1'b0));
    send_settings_item(poll_item(2, 1'b0, 1'b1));
    send_settings_item(poll_item(2, 1'b1, 1'b1));
    send_settings_item(restore_item(2));
    send_settings_item(build_item(CMD_SEED, 2, 8'h41, 8'h00, 8'h00, 1'b0));
    run_random_scans(40);
    drain_results();
  endtask

  // a restore with three different copies halts the store until reset
  task automatic test_fault_halt();
    send_settings_item(build_item(CMD_RESTORE, 10, 8'h00, 8'hFF, 8'h5A, 1'b0));
    run_random_scans(20);
    drain_results();
    write_wear_limit(14'd5000);
    run_random_scans(8);
    drain_results();
  endtask

  always @(posedge clk) begin : sink_stall
    int hold_left;
    int stall_mode;
    int stall_age;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    stall_age++;
    if (stall_age >= 48) begin
      stall_mode = $urandom_range(0, 3);
      stall_age = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (stall_age % 4 == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    tcss_result_t got;
    tcss_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = tcss_kind_t'(m_axis_tuser);
      got.nv_address = m_axis_tdata[7:0];
      got.out_data = m_axis_tdata[15:8];
      got.write_disabled = m_axis_tdata[16];
      got.last = m_axis_tlast;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: kind=%0d addr=%02h data=%02h wd=%0b last=%0b",
                                got.kind, got.nv_address, got.out_data, got.write_disabled,
                                got.last));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.nv_address !== want.nv_address ||
            got.out_data !== want.out_data || got.write_disabled !== want.write_disabled ||
            got.last !== want.last) begin
          note_mismatch($sformatf({"result mismatch: expected kind=%0d addr=%02h data=%02h ",
                                   "wd=%0b last=%0b, got kind=%0d addr=%02h data=%02h ",
                                   "wd=%0b last=%0b"},
                                  want.kind, want.nv_address, want.out_data,
                                  want.write_disabled, want.last, got.kind, got.nv_address,
                                  got.out_data, got.write_disabled, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_triple_copy_settings_store: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic();
    test_backpressure();
    test_limit_boundary();
    test_changed_polls();
    test_wear_lockout();
    test_fault_halt();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_triple_copy_settings_store: PASS");
    end else begin
      $display("tb_triple_copy_settings_store: FAIL");
    end
    $finish;
  end

endmodule
